// ===== src/longest_common_substring_defines.svh =====
// Assertion helpers used by the top-level RTL.
`ifndef LONGEST_COMMON_SUBSTRING_DEFINES_SVH
`define LONGEST_COMMON_SUBSTRING_DEFINES_SVH

// Same-cycle implication, gated by reset.
`define LCS_AST_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, gated by reset.
`define LCS_AST_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/lcs_pkg.sv =====
package lcs_pkg;

  localparam int MAX_LEN_DEF = 256;

  localparam int IN_DATA_W   = 8;
  localparam int LEN_OUT_W   = 9;
  localparam int START_OUT_W = 8;
  localparam int OUT_DATA_W  = 24;

  localparam logic OP_A = 1'b0;
  localparam logic OP_B = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_ROW    = 5'b00010,
    S_SCAN   = 5'b00100,
    S_ROWEND = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  typedef struct packed {
    logic load;
    logic start;
    logic row_begin;
    logic scan;
    logic row_end;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic term;
    logic rows_done;
    logic scan_done;
    logic out_free;
  } status_t;

endpackage

// ===== src/longest_common_substring.sv =====
// Channel  | Dir | Ports                     | Contents
// in_      | in  | tvalid tready tdata tuser | tdata[7:0] char_value; tuser operation
// out_     | out | tvalid tready tdata tuser | tdata[8:0] length, [16:9] start; tuser truncated
//
// A byte of A or B is taken whenever the block is idle.
// B's zero byte starts the search: a row per byte of B, each scanning all of A (none when A is
// empty); the string RAMs and the run RAM have registered reads.
// Input is stalled during the search; a waiting result does not stall loading,
// but the next search holds in its last cycle until the result register is free.
// rst_n is synchronous, active low; it empties both strings and the result.
`include "longest_common_substring_defines.svh"

module longest_common_substring #(
  parameter int MAX_LEN = lcs_pkg::MAX_LEN_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [lcs_pkg::IN_DATA_W-1:0]  in_tdata,   // [7:0] char_value
  input  logic                           in_tuser,   // [0] operation
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [lcs_pkg::OUT_DATA_W-1:0] out_tdata,  // [8:0] match_length, [16:9] match_start
  output logic                           out_tuser   // [0] truncated
);

  import lcs_pkg::*;

  cmd_t    cmd;
  status_t st;
  logic    term_fire;

  lcs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  lcs_dp #(.MAX_LEN(MAX_LEN)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  assign term_fire = in_tvalid && in_tready && (in_tuser == OP_B) && (in_tdata == '0);

  `LCS_AST_IMP(a_result_after_search, $rose(out_tvalid), !$past(in_tready), "result without search")
  `LCS_AST_IMP(a_empty_start, out_tvalid && (out_tdata[8:0] == '0), out_tdata[16:9] == '0, "bad start")
  `LCS_AST_NXT(a_term_stalls, term_fire, !in_tready, "input taken during search")

endmodule

// ===== src/lcs_ram.sv =====
module lcs_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/lcs_ctrl.sv =====
module lcs_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  lcs_pkg::status_t st,
  output lcs_pkg::cmd_t    cmd
);

  import lcs_pkg::*;

  state_t state_r, state_nxt;
  logic   fire;

  assign in_tready = (state_r == S_IDLE);
  assign fire      = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.load  = fire;
    unique case (state_r)
      S_IDLE: begin
        if (fire && st.term) begin
          cmd.start = 1'b1;
          state_nxt = S_ROW;
        end
      end
      S_ROW: begin
        if (st.rows_done) begin
          state_nxt = S_DONE;
        end else begin
          cmd.row_begin = 1'b1;
          state_nxt     = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (st.scan_done) begin
          state_nxt = S_ROWEND;
        end
      end
      S_ROWEND: begin
        cmd.row_end = 1'b1;
        state_nxt   = S_ROW;
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== src/lcs_dp.sv =====
module lcs_dp #(
  parameter int MAX_LEN = lcs_pkg::MAX_LEN_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  lcs_pkg::cmd_t                   cmd,
  output lcs_pkg::status_t                st,
  input  logic [lcs_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [lcs_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                            out_tuser
);

  import lcs_pkg::*;

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int LW = $clog2(MAX_LEN + 1);
  localparam logic [LW-1:0] MAX_L = LW'(MAX_LEN);

  logic [LW-1:0] len_a_r, len_a_nxt, len_b_r, len_b_nxt;
  logic          ovf_r, ovf_nxt;
  logic [LW-1:0] row_r, row_nxt;
  logic [LW-1:0] ai_r, ai_nxt;
  logic [AW-1:0] ac_r, ac_nxt;
  logic          cv_r, cv_nxt;
  logic          first_r, first_nxt;
  logic [LW-1:0] rbest_r, rbest_nxt, best_r, best_nxt;
  logic [AW-1:0] rstart_r, rstart_nxt, bstart_r, bstart_nxt;
  logic          oval_r, oval_nxt;
  logic [LEN_OUT_W-1:0]   olen_r, olen_nxt;
  logic [START_OUT_W-1:0] ostart_r, ostart_nxt;
  logic                   otrunc_r, otrunc_nxt;

  logic          nz, a_we, b_we, issue;
  logic [IN_DATA_W-1:0] a_dout, b_dout;
  logic [LW-1:0] run_dout, run_in, v;
  logic          last_col;

  assign nz    = (in_tdata != '0);
  assign a_we  = cmd.load && (in_tuser == OP_A) && nz && (len_a_r < MAX_L);
  assign b_we  = cmd.load && (in_tuser == OP_B) && nz && (len_b_r < MAX_L);
  assign issue = cmd.scan && (ai_r != len_a_r);

  lcs_ram #(.W(IN_DATA_W), .DEPTH(MAX_LEN)) u_ram_a (
    .clk   (clk),
    .we    (a_we),
    .waddr (len_a_r[AW-1:0]),
    .wdata (in_tdata),
    .re    (issue),
    .raddr (ai_r[AW-1:0]),
    .rdata (a_dout)
  );

  lcs_ram #(.W(IN_DATA_W), .DEPTH(MAX_LEN)) u_ram_b (
    .clk   (clk),
    .we    (b_we),
    .waddr (len_b_r[AW-1:0]),
    .wdata (in_tdata),
    .re    (cmd.row_begin),
    .raddr (AW'(row_r - 1'b1)),
    .rdata (b_dout)
  );

  // run[a] of the row below; first row and the column past A read as zero
  lcs_ram #(.W(LW), .DEPTH(MAX_LEN)) u_ram_run (
    .clk   (clk),
    .we    (cv_r),
    .waddr (ac_r),
    .wdata (v),
    .re    (issue),
    .raddr (AW'(ai_r[AW-1:0] + 1'b1)),
    .rdata (run_dout)
  );

  assign last_col = ((LW'(ac_r) + 1'b1) == len_a_r);
  assign run_in   = (first_r || last_col) ? '0 : run_dout;
  assign v        = (a_dout == b_dout) ? LW'(run_in + 1'b1) : '0;

  assign st.term      = (in_tuser == OP_B) && !nz;
  assign st.rows_done = (row_r == '0) || (len_a_r == '0);
  assign st.scan_done = (ai_r == len_a_r) && !cv_r;
  assign st.out_free  = !oval_r || out_tready;

  always_comb begin
    len_a_nxt  = len_a_r;
    len_b_nxt  = len_b_r;
    ovf_nxt    = ovf_r;
    row_nxt    = row_r;
    ai_nxt     = ai_r;
    ac_nxt     = ac_r;
    cv_nxt     = cv_r;
    first_nxt  = first_r;
    rbest_nxt  = rbest_r;
    rstart_nxt = rstart_r;
    best_nxt   = best_r;
    bstart_nxt = bstart_r;
    oval_nxt   = oval_r && !out_tready;
    olen_nxt   = olen_r;
    ostart_nxt = ostart_r;
    otrunc_nxt = otrunc_r;

    if (a_we) begin
      len_a_nxt = len_a_r + 1'b1;
    end
    if (b_we) begin
      len_b_nxt = len_b_r + 1'b1;
    end
    if (cmd.load && nz && !a_we && !b_we) begin
      ovf_nxt = 1'b1;
    end

    if (cmd.start) begin
      row_nxt    = len_b_r;
      best_nxt   = '0;
      bstart_nxt = '0;
      first_nxt  = 1'b1;
    end

    if (cmd.row_begin) begin
      row_nxt    = row_r - 1'b1;
      ai_nxt     = '0;
      cv_nxt     = 1'b0;
      rbest_nxt  = '0;
      rstart_nxt = '0;
    end

    if (cmd.scan) begin
      cv_nxt = issue;
      if (issue) begin
        ai_nxt = ai_r + 1'b1;
        ac_nxt = ai_r[AW-1:0];
      end
      if (cv_r && (v > rbest_r)) begin
        rbest_nxt  = v;
        rstart_nxt = ac_r;
      end
    end

    // rows run from last to first, so ties go to the earlier row
    if (cmd.row_end) begin
      first_nxt = 1'b0;
      if ((rbest_r != '0) && (rbest_r >= best_r)) begin
        best_nxt   = rbest_r;
        bstart_nxt = rstart_r;
      end
    end

    if (cmd.finish) begin
      oval_nxt   = 1'b1;
      olen_nxt   = LEN_OUT_W'(best_r);
      ostart_nxt = START_OUT_W'(bstart_r);
      otrunc_nxt = ovf_r;
      len_a_nxt  = '0;
      len_b_nxt  = '0;
      ovf_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_a_r <= '0;
      len_b_r <= '0;
      ovf_r   <= 1'b0;
      oval_r  <= 1'b0;
      cv_r    <= 1'b0;
    end else begin
      len_a_r <= len_a_nxt;
      len_b_r <= len_b_nxt;
      ovf_r   <= ovf_nxt;
      oval_r  <= oval_nxt;
      cv_r    <= cv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r    <= row_nxt;
    ai_r     <= ai_nxt;
    ac_r     <= ac_nxt;
    first_r  <= first_nxt;
    rbest_r  <= rbest_nxt;
    rstart_r <= rstart_nxt;
    best_r   <= best_nxt;
    bstart_r <= bstart_nxt;
    olen_r   <= olen_nxt;
    ostart_r <= ostart_nxt;
    otrunc_r <= otrunc_nxt;
  end

  assign out_tvalid = oval_r;
  assign out_tdata  = OUT_DATA_W'({ostart_r, olen_r});
  assign out_tuser  = otrunc_r;

endmodule
